[sv/wrms_pkg.sv]
// wrms_pkg: widths, configuration register indexes and shared types for the
// windowed rms block with noise correction; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wrms_pkg;

    // sample and record limits
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = 20;
    localparam int LEN_W       = IDX_W + 1;
    localparam int MAX_SAMPLES = 2 ** IDX_W;

    // square of a magnitude up to 2**(SAMPLE_BITS-1)
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    // sum of up to MAX_SAMPLES squares
    localparam int SUM_W  = SQ_W + IDX_W;
    // mean square never exceeds one square
    localparam int MS_W   = SQ_W;
    localparam int ROOT_W = SAMPLE_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LEN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SIG_WIN_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEN   = 3'd5;

    localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(MAX_SAMPLES);

    typedef struct packed {
        logic             signal_window_enable;
        logic [IDX_W-1:0] signal_start;
        logic [LEN_W-1:0] signal_length;
        logic             noise_enable;
        logic [IDX_W-1:0] noise_start;
        logic [LEN_W-1:0] noise_length;
    } cfg_t;

    // one classified beat handed from front to back
    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic             sig_hit;
        logic             noise_hit;
        logic             last;
        logic [LEN_W-1:0] count;
    } q_entry_t;

endpackage

`default_nettype wire

[sv/wrms_if.sv]
// wrms_sample_if and wrms_result_if: valid/ready channels of the block
// depends on wrms_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface wrms_sample_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [wrms_pkg::SAMPLE_BITS-1:0] sample;
    logic                                    is_last;

    modport source (output valid, output sample, output is_last, input ready);
    modport sink (input valid, input sample, input is_last, output ready);
endinterface

interface wrms_result_if;
    logic                        valid;
    logic                        ready;
    logic [wrms_pkg::ROOT_W-1:0] rms;
    logic                        noise_dominant;

    modport source (output valid, output rms, output noise_dominant, input ready);
    modport sink (input valid, input rms, input noise_dominant, output ready);
endinterface

`default_nettype wire

[sv/wrms_front.sv]
// wrms_front: takes sample beats, squares them and marks window membership
// depends on wrms_pkg and wrms_sample_if
`timescale 1ns / 1ps
`default_nettype none

module wrms_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wrms_pkg::cfg_t     cfg,
    wrms_sample_if.sink             samples,
    input  wire logic               q_full,
    output wrms_pkg::q_entry_t      entry,
    output logic                    push
);
    import wrms_pkg::*;

    logic [LEN_W-1:0]         count_reg;
    logic [LEN_W-1:0]         count_next;
    logic [LEN_W-1:0]         count_after;
    logic                     active;
    logic [IDX_W-1:0]         idx;
    logic [SAMPLE_BITS-1:0]   raw;
    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] prod;
    logic [LEN_W-1:0]         sig_off;
    logic [LEN_W-1:0]         noise_off;
    logic                     in_sig;
    logic                     in_noise;

    // beats are taken whenever the queue has room
    assign samples.ready = !q_full;
    assign push          = samples.valid && !q_full;

    // samples beyond the record limit are not counted
    assign active = (count_reg < LEN_W'(MAX_SAMPLES));
    assign idx    = count_reg[IDX_W-1:0];

    // magnitude and square
    assign raw  = samples.sample;
    assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign prod = mag * mag;

    // window membership of this sample
    assign sig_off   = {1'b0, idx} - {1'b0, cfg.signal_start};
    assign noise_off = {1'b0, idx} - {1'b0, cfg.noise_start};
    assign in_sig    = (idx >= cfg.signal_start) && (sig_off < cfg.signal_length);
    assign in_noise  = (idx >= cfg.noise_start) && (noise_off < cfg.noise_length);

    assign count_after = count_reg + LEN_W'(active);

    always_comb
    begin
        entry.sq        = prod[SQ_W-1:0];
        entry.sig_hit   = active && (!cfg.signal_window_enable || in_sig);
        entry.noise_hit = active && cfg.noise_enable && in_noise;
        entry.last      = samples.is_last;
        entry.count     = count_after;
    end

    // record position, cleared after the last beat
    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = samples.is_last ? '0 : count_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[sv/wrms_queue.sv]
// wrms_queue: short first-in first-out queue of classified beats
// depends on wrms_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module wrms_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire wrms_pkg::q_entry_t wr_entry,
    input  wire logic               pop,
    output wrms_pkg::q_entry_t      head,
    output logic                    full,
    output logic                    empty
);
    import wrms_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // pointer wrap and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

[sv/wrms_back.sv]
// wrms_back: accumulates squares, then divides, corrects and takes the root
// depends on wrms_pkg and wrms_result_if
`timescale 1ns / 1ps
`default_nettype none

module wrms_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wrms_pkg::cfg_t     cfg,
    input  wire wrms_pkg::q_entry_t head,
    input  wire logic               empty,
    output logic                    pop,
    wrms_result_if.source           results
);
    import wrms_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    localparam logic [2:0] ST_ACC       = 3'd0;
    localparam logic [2:0] ST_DIV_SIG   = 3'd1;
    localparam logic [2:0] ST_DIV_NOISE = 3'd2;
    localparam logic [2:0] ST_SUB       = 3'd3;
    localparam logic [2:0] ST_SQRT      = 3'd4;
    localparam logic [2:0] ST_OUT       = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sig_sum_reg, sig_sum_next;
    logic [SUM_W-1:0]    noise_sum_reg, noise_sum_next;
    logic [SUM_W-1:0]    num_reg, num_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [LEN_W-1:0]    den_reg, den_next;
    logic [MS_W-1:0]     sig_ms_reg, sig_ms_next;
    logic [MS_W-1:0]     noise_ms_reg, noise_ms_next;
    logic                flag_reg, flag_next;
    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W:0]     srem_reg, srem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W-1:0]   rms_reg, rms_next;
    logic                dom_reg, dom_next;
    logic                out_valid_reg, out_valid_next;

    logic [SUM_W-1:0]  acc_sig;
    logic [SUM_W-1:0]  acc_noise;
    logic [LEN_W:0]    div_shift;
    logic              div_ge;
    logic [LEN_W:0]    div_rem;
    logic [SUM_W-1:0]  div_quot;
    logic              div_done;
    logic [MS_W-1:0]   div_result;
    logic [ROOT_W+2:0] sq_shift;
    logic [ROOT_W+2:0] sq_trial;
    logic              sq_ge;
    logic [ROOT_W+2:0] sq_rem;
    logic              sq_done;
    logic              out_load;

    assign results.valid          = out_valid_reg;
    assign results.rms            = rms_reg;
    assign results.noise_dominant = dom_reg;

    assign pop = (state_reg == ST_ACC) && !empty;

    // running sums with the head beat added
    assign acc_sig   = sig_sum_reg + (head.sig_hit ? SUM_W'(head.sq) : '0);
    assign acc_noise = noise_sum_reg + (head.noise_hit ? SUM_W'(head.sq) : '0);

    // restoring divider, one quotient bit a cycle
    assign div_shift  = {rem_reg, num_reg[SUM_W-1]};
    assign div_ge     = (div_shift >= {1'b0, den_reg});
    assign div_rem    = div_ge ? (div_shift - {1'b0, den_reg}) : div_shift;
    assign div_quot   = {num_reg[SUM_W-2:0], div_ge};
    assign div_done   = (cnt_reg == CNT_W'(SUM_W - 1));
    assign div_result = (den_reg == '0) ? '0 : div_quot[MS_W-1:0];

    // digit-by-digit square root, one root bit a cycle
    assign sq_shift = {srem_reg, rad_reg[2*ROOT_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);
    assign sq_rem   = sq_ge ? (sq_shift - sq_trial) : sq_shift;
    assign sq_done  = (cnt_reg == CNT_W'(ROOT_W - 1));

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || results.ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sig_sum_next   = sig_sum_reg;
        noise_sum_next = noise_sum_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        sig_ms_next    = sig_ms_reg;
        noise_ms_next  = noise_ms_reg;
        flag_next      = flag_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        rms_next       = rms_reg;
        dom_next       = dom_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_ACC:
            begin
                if (!empty)
                begin
                    sig_sum_next   = acc_sig;
                    noise_sum_next = acc_noise;
                    if (head.last)
                    begin
                        num_next   = acc_sig;
                        rem_next   = '0;
                        den_next   = cfg.signal_window_enable ? cfg.signal_length
                                                              : head.count;
                        cnt_next   = '0;
                        state_next = ST_DIV_SIG;
                    end
                end
            end
            ST_DIV_SIG:
            begin
                num_next = div_quot;
                rem_next = div_rem[LEN_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (div_done)
                begin
                    sig_ms_next = div_result;
                    cnt_next    = '0;
                    if (cfg.noise_enable)
                    begin
                        num_next   = noise_sum_reg;
                        rem_next   = '0;
                        den_next   = cfg.noise_length;
                        state_next = ST_DIV_NOISE;
                    end
                    else
                    begin
                        noise_ms_next = '0;
                        state_next    = ST_SUB;
                    end
                end
            end
            ST_DIV_NOISE:
            begin
                num_next = div_quot;
                rem_next = div_rem[LEN_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (div_done)
                begin
                    noise_ms_next = div_result;
                    cnt_next      = '0;
                    state_next    = ST_SUB;
                end
            end
            ST_SUB:
            begin
                // noise above signal clamps to zero
                flag_next = (noise_ms_reg > sig_ms_reg);
                rad_next  = flag_next ? '0
                                      : (2*ROOT_W)'(sig_ms_reg - noise_ms_reg);
                srem_next  = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                srem_next = sq_rem[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                rad_next  = {rad_reg[2*ROOT_W-3:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (sq_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    rms_next       = root_reg;
                    dom_next       = flag_reg;
                    out_valid_next = 1'b1;
                    sig_sum_next   = '0;
                    noise_sum_next = '0;
                    state_next     = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    // control state and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            cnt_reg       <= '0;
            sig_sum_reg   <= '0;
            noise_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sig_sum_reg   <= sig_sum_next;
            noise_sum_reg <= noise_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        sig_ms_reg   <= sig_ms_next;
        noise_ms_reg <= noise_ms_next;
        flag_reg     <= flag_next;
        rad_reg      <= rad_next;
        srem_reg     <= srem_next;
        root_reg     <= root_next;
        rms_reg      <= rms_next;
        dom_reg      <= dom_next;
    end

endmodule

`default_nettype wire

[sv/windowed_rms_noise_corrected.sv]
// windowed rms with noise correction: one sample beat per cycle while a record
// streams in and the queue has room; after the last beat is accepted it divides
// out the signal mean square, then the noise mean square if enabled, then takes
// the root; beats keep being taken meanwhile until the 4-entry queue is full
// reset clears record position, sums and pending result; registers return to
// windowing and noise off, starts 0, lengths 1048576
`timescale 1ns / 1ps
`default_nettype none

module windowed_rms_noise_corrected #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [wrms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wrms_pkg::CFG_DATA_W-1:0] cfg_data,
    wrms_sample_if.sink                        samples,
    wrms_result_if.source                      results
);
    import wrms_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    q_entry_t wr_entry;
    q_entry_t head;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_SIG_WIN_EN:  cfg_next.signal_window_enable = cfg_data[0];
                CFG_SIG_START:   cfg_next.signal_start = cfg_data[IDX_W-1:0];
                CFG_SIG_LENGTH:  cfg_next.signal_length = cfg_data[LEN_W-1:0];
                CFG_NOISE_EN:    cfg_next.noise_enable = cfg_data[0];
                CFG_NOISE_START: cfg_next.noise_start = cfg_data[IDX_W-1:0];
                CFG_NOISE_LEN:   cfg_next.noise_length = cfg_data[LEN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.signal_window_enable <= 1'b0;
            cfg_reg.signal_start         <= '0;
            cfg_reg.signal_length        <= LENGTH_RESET;
            cfg_reg.noise_enable         <= 1'b0;
            cfg_reg.noise_start          <= '0;
            cfg_reg.noise_length         <= LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify beats
    wrms_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .samples (samples),
        .q_full  (q_full),
        .entry   (wr_entry),
        .push    (push)
    );

    // decouple front and back
    wrms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // accumulate and finish the record
    wrms_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .empty   (q_empty),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire

[sv/wrms_checker.sv]
// wrms_checker: port-level checks on the result channel, bound to the top level
// depends on wrms_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

module wrms_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [wrms_pkg::ROOT_W-1:0] out_rms,
    input wire logic                        out_dom
);
    import wrms_pkg::*;

    // a stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // a stalled result beat keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_rms) && $stable(out_dom))
        else $error("result beat changed while stalled");

    // clamped results carry a zero root
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_dom |-> out_rms == '0)
        else $error("noise dominant result with nonzero rms");

    // root of a mean square never exceeds full-scale magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_rms <= ROOT_W'(2 ** (SAMPLE_BITS - 1)))
        else $error("rms above full scale");

endmodule

bind windowed_rms_noise_corrected wrms_checker u_wrms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_rms   (results.rms),
    .out_dom   (results.noise_dominant)
);

`default_nettype wire
